// File: src/brr_pkg.sv
// ----------------------------------------------------------------------------
// brr_pkg: shared types and constants for the line resampler
// Field widths, register indexes and the result beat structure.
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int LEN_W          = 13;
  localparam int SAMPLE_W       = 32;
  localparam int DEC_W          = 16;
  localparam int DEF_MAX_LENGTH = 4096;
  localparam int DEF_MAX_RUN    = 64;

  localparam logic REG_IN_LENGTH  = 1'b0;
  localparam logic REG_OUT_LENGTH = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                run_last;
    logic                line_last;
  } result_t;

endpackage

// File: src/brr_step.sv
// ----------------------------------------------------------------------------
// brr_step: shared decision and max unit
// One Bresenham decision update and one signed max compare per cycle.
// ----------------------------------------------------------------------------
module brr_step import brr_pkg::*; (
  input  logic [DEC_W-1:0]    dec,
  input  logic [DEC_W-1:0]    d1,
  input  logic [DEC_W-1:0]    d2,
  input  logic [SAMPLE_W-1:0] smp,
  input  logic [SAMPLE_W-1:0] hm,
  output logic [DEC_W-1:0]    sum,
  output logic                advance,
  output logic [SAMPLE_W-1:0] hm_max
);

  assign advance = ~dec[DEC_W-1];
  assign sum     = dec + (advance ? d2 : d1);
  assign hm_max  = ($signed(smp) > $signed(hm)) ? smp : hm;

endmodule

// File: src/brr_out_reg.sv
// ----------------------------------------------------------------------------
// brr_out_reg: output register
// Holds one result beat toward the master side until it is taken.
// ----------------------------------------------------------------------------
module brr_out_reg import brr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  result_t             in_beat,
  output logic                in_ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // value
  output logic                m_tlast,   // run_last
  output logic                m_tuser    // line_last
);

  result_t beat;

  assign in_ready = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat <= in_beat;
    end
  end

  assign m_tdata = beat.value;
  assign m_tlast = beat.run_last;
  assign m_tuser = beat.line_last;

endmodule

// File: src/bresenham_resample_replicate_max.sv
// ----------------------------------------------------------------------------
// bresenham_resample_replicate_max: Bresenham line resampler
// Resamples lines of in_length samples to out_length samples.
//
// Usage:
//   Slave side carries one sample per beat (tdata) with a line start flag
//   in tuser. Master side carries result beats: value in tdata, the last
//   result of an input in tlast, the out_length-th result of a line in tuser.
//   in_length and out_length are written through cfg_we/cfg_index/cfg_data
//   while the block is idle.
// Timing:
//   Copy and compression accept one sample per cycle while the master side
//   keeps up. Expansion emits nothing on the accepting edge, then runs its
//   steps from a single shared decision adder, up to MAX_RUN steps, and the
//   slave side is held off until the run ends. Steps dropped past the end
//   of a line still run and advance the decision.
//   A result passes a result register and an output register: copy and
//   compression results enter the result register on the accepting edge,
//   the first result of a run on the first run step.
// Reset: lengths return to one, decision, held max and count to zero.
// Stall: a stalled master side fills both registers, then tready drops.
// ----------------------------------------------------------------------------
module bresenham_resample_replicate_max import brr_pkg::*; #(
  parameter int MAX_LENGTH = DEF_MAX_LENGTH,
  parameter int MAX_RUN    = DEF_MAX_RUN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [LEN_W-1:0]    cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // sample
  input  logic                s_tuser,   // line_start
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // value
  output logic                m_tlast,   // run_last
  output logic                m_tuser    // line_last
);

  localparam int KW = $clog2(MAX_RUN);
  localparam logic [KW-1:0] K_LAST = KW'(MAX_RUN - 1);
  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_LENGTH > (2 ** LEN_W) - 1) ? {LEN_W{1'b1}} : LEN_W'(MAX_LENGTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                st;
  logic [LEN_W-1:0]    in_length;
  logic [LEN_W-1:0]    out_length;
  logic [DEC_W-1:0]    decision;
  logic [SAMPLE_W-1:0] held_max;
  logic [LEN_W-1:0]    emitted_count;
  logic [SAMPLE_W-1:0] smp_hold;
  logic [DEC_W-1:0]    d1_r;
  logic [DEC_W-1:0]    d2_r;
  logic [LEN_W-1:0]    nb_r;
  logic [KW-1:0]       k;
  logic                res_valid;
  result_t             res;

  logic [LEN_W-1:0]    na;
  logic [LEN_W-1:0]    nb;
  logic [DEC_W-1:0]    d1;
  logic [DEC_W-1:0]    d2;
  logic                expand;
  logic                same;
  logic [DEC_W-1:0]    dec_base;
  logic [SAMPLE_W-1:0] hm_base;
  logic [LEN_W-1:0]    ec_base;
  logic [LEN_W-1:0]    ec_inc;
  logic                accept;
  logic                res_ready;
  logic                res_move;
  logic                res_free;
  logic                res_load;
  logic                run_step;
  logic                run_final;
  logic                put_ok;
  logic [DEC_W-1:0]    u_dec;
  logic [DEC_W-1:0]    u_d1;
  logic [DEC_W-1:0]    u_d2;
  logic [DEC_W-1:0]    u_sum;
  logic                u_adv;
  logic [SAMPLE_W-1:0] u_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_length  <= LEN_W'(1);
      out_length <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_LENGTH:  in_length  <= cfg_data;
        REG_OUT_LENGTH: out_length <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_comb begin
    na     = (in_length > LEN_CAP) ? LEN_CAP : in_length;
    nb     = (out_length > LEN_CAP) ? LEN_CAP : out_length;
    expand = na < nb;
    same   = na == nb;
    if (expand) begin
      d1 = {2'b00, na, 1'b0};
      d2 = d1 - {2'b00, nb, 1'b0};
    end else begin
      d1 = {2'b00, nb, 1'b0};
      d2 = d1 - {2'b00, na, 1'b0};
    end
    if (s_tuser) begin
      dec_base = expand ? d2 : (d1 - {3'b000, na});
      hm_base  = '0;
      ec_base  = '0;
    end else begin
      dec_base = decision;
      hm_base  = held_max;
      ec_base  = emitted_count;
    end
  end

  assign res_move  = res_valid && res_ready;
  assign res_free  = !res_valid || res_move;
  assign s_tready  = (st == ST_IDLE) && res_free;
  assign accept    = s_tvalid && s_tready;
  assign run_step  = (st == ST_RUN) && res_free;

  assign u_dec = (st == ST_RUN) ? decision : dec_base;
  assign u_d1  = (st == ST_RUN) ? d1_r : d1;
  assign u_d2  = (st == ST_RUN) ? d2_r : d2;

  brr_step u_step (
    .dec     (u_dec),
    .d1      (u_d1),
    .d2      (u_d2),
    .smp     (s_tdata),
    .hm      (hm_base),
    .sum     (u_sum),
    .advance (u_adv),
    .hm_max  (u_max)
  );

  assign run_final = u_adv || (k == K_LAST);
  assign ec_inc    = ((st == ST_RUN) ? emitted_count : ec_base) + LEN_W'(1);
  assign put_ok    = (st == ST_RUN) ? (emitted_count < nb_r) : (ec_base < nb);
  assign res_load  = put_ok && ((accept && (same || (!expand && u_adv))) || run_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      res_valid     <= 1'b0;
      decision      <= '0;
      held_max      <= '0;
      emitted_count <= '0;
      k             <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        priority if (same) begin
          decision      <= dec_base;
          held_max      <= hm_base;
          emitted_count <= put_ok ? ec_inc : ec_base;
          res.value     <= s_tdata;
          res.run_last  <= 1'b1;
          res.line_last <= ec_inc == nb;
        end else if (expand) begin
          decision      <= dec_base;
          held_max      <= hm_base;
          emitted_count <= ec_base;
          smp_hold      <= s_tdata;
          d1_r          <= d1;
          d2_r          <= d2;
          nb_r          <= nb;
          k             <= '0;
          st            <= ST_RUN;
        end else begin
          decision <= u_sum;
          if (u_adv) begin
            held_max      <= '0;
            emitted_count <= put_ok ? ec_inc : ec_base;
            res.value     <= u_max;
            res.run_last  <= 1'b1;
            res.line_last <= ec_inc == nb;
          end else begin
            held_max      <= u_max;
            emitted_count <= ec_base;
          end
        end
      end else if (run_step) begin
        decision <= u_sum;
        if (put_ok) begin
          emitted_count <= ec_inc;
          res.value     <= smp_hold;
          res.run_last  <= run_final || (ec_inc == nb_r);
          res.line_last <= ec_inc == nb_r;
        end
        if (run_final) begin
          st <= ST_IDLE;
        end else begin
          k <= k + KW'(1);
        end
      end
    end
  end

  brr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_beat  (res),
    .in_ready (res_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  a_expand_starts: assert property (@(posedge clk) disable iff (rst)
    accept && expand |=> st == ST_RUN)
    else $error("accepted expansion beat did not start a run");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result lost or changed while output stalled");

  a_run_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RUN) && res_valid && !res_ready |=> $stable(decision) && $stable(k))
    else $error("run advanced while result register was full");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run_step && (k == K_LAST) |=> st == ST_IDLE)
    else $error("expansion run exceeded its cap");

endmodule

// File: dv/tb_bresenham_resample_replicate_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_resample_replicate_max: self-checking bench for the resampler
// Streams lines of samples through the block under many length settings
// (copy, replicate expansion, max-hold compression, zero and clamped lengths)
// and compares every result beat with an in-bench prediction of the line
// state. Random idle bursts on both sides, one long output stall.
// ----------------------------------------------------------------------------
module tb_bresenham_resample_replicate_max;
  import brr_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RST_CYCLES   = 12;
  localparam int SETTLE       = 8;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 350;
  localparam int MAX_PRINT    = 20;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                start;
  } sample_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_IN_LENGTH;
  logic [LEN_W-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;   // sample
  logic                s_tuser = 1'b0; // line_start
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;        // value
  logic                m_tlast;        // run_last
  logic                m_tuser;        // line_last

  bresenham_resample_replicate_max i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Line resampler state as the block should hold it
  logic [LEN_W-1:0]        in_len = 13'd1;
  logic [LEN_W-1:0]        out_len = 13'd1;
  logic signed [DEC_W-1:0] dec_var = '0;
  logic [SAMPLE_W-1:0]     run_max = '0;
  int                      line_cnt = 0;

  sample_beat_t pend_q[$];
  result_t      step_q[$];
  result_t      res_exp_q[$];

  int  err_cnt = 0;
  int  acc_cnt = 0;
  int  res_cnt = 0;
  int  cfg_cnt = 0;
  int  idle_pct = 0;
  bit  quiet = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  int  cyc = 0;

  function automatic int clamp_len(input logic [LEN_W-1:0] r);
    return (int'(r) > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : int'(r);
  endfunction

  function automatic void put_result(input logic [SAMPLE_W-1:0] v, input int nb);
    result_t r;
    if (line_cnt >= nb) return;
    line_cnt++;
    r.value     = v;
    r.run_last  = 1'b0;
    r.line_last = (line_cnt == nb);
    step_q.push_back(r);
  endfunction

  function automatic void resample_predict(input logic [SAMPLE_W-1:0] smp,
                                           input logic start);
    int      na, nb, d1, d2;
    logic    adv;
    result_t r;
    na = clamp_len(in_len);
    nb = clamp_len(out_len);
    if (na < nb) begin
      d1 = 2 * na;
      d2 = d1 - 2 * nb;
    end else begin
      d1 = 2 * nb;
      d2 = d1 - 2 * na;
    end
    if (start) begin
      dec_var  = (na < nb) ? 16'(d2) : 16'(d1 - na);
      run_max  = '0;
      line_cnt = 0;
    end
    if (na == nb) begin
      put_result(smp, nb);
    end else if (na < nb) begin
      for (int k = 0; k < DEF_MAX_RUN; k++) begin
        adv = (dec_var >= 0);
        put_result(smp, nb);
        dec_var = 16'(dec_var + (adv ? d2 : d1));
        if (adv) break;
      end
    end else begin
      if ($signed(smp) > $signed(run_max)) run_max = smp;
      if (dec_var < 0) begin
        dec_var = 16'(dec_var + d1);
      end else begin
        dec_var = 16'(dec_var + d2);
        put_result(run_max, nb);
        run_max = '0;
      end
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.run_last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) res_exp_q.push_back(step_q[i]);
    step_q.delete();
  endfunction

  // Input side
  always @(posedge clk) begin : drive
    sample_beat_t it;
    logic         v;
    int           tx_gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        resample_predict(s_tdata, s_tuser);
        acc_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        v = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pend_q.size() == 0) begin
          v = 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
          tx_gap = $urandom_range(1, 12) - 1;
        end else begin
          it = pend_q.pop_front();
          v  = 1'b1;
          s_tdata <= it.sample;
          s_tuser <= it.start;
        end
        s_tvalid <= v;
      end
    end
  end

  // Output side
  always @(posedge clk) begin : receive
    result_t want;
    logic    rdy;
    int      rx_gap;
    int      hold_cnt;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   = 0;
      hold_cnt = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        res_cnt++;
        if (res_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_PRINT)
            $display("%0t: unexpected result value %h run_last %b line_last %b",
                     $time, m_tdata, m_tlast, m_tuser);
        end else begin
          want = res_exp_q.pop_front();
          if (want.value !== m_tdata || want.run_last !== m_tlast ||
              want.line_last !== m_tuser) begin
            err_cnt++;
            if (err_cnt <= MAX_PRINT)
              $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                       want.value, want.run_last, want.line_last,
                       m_tdata, m_tlast, m_tuser);
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_cnt = LONG_HOLD;
      end
      rdy = 1'b0;
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        rx_gap = $urandom_range(1, 12) - 1;
      end else begin
        rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, res_exp_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void queue_beat(input logic [SAMPLE_W-1:0] smp, input logic start);
    sample_beat_t b;
    b.sample = smp;
    b.start  = start;
    pend_q.push_back(b);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'(0 - $urandom_range(1, 65536));
      4:       return 32'($urandom_range(1, 65536));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_extreme_len();
    case ($urandom_range(0, 7))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd4095;
      3:       return 13'd4096;
      4:       return 13'd4097;
      5:       return 13'h1FFF;
      default: return 13'($urandom_range(1, 24));
    endcase
  endfunction

  // Wait for the block to go quiet: nothing pending, nothing expected, no run
  task automatic settle();
    do @(negedge clk);
    while (pend_q.size() != 0 || s_tvalid || !s_tready || res_exp_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_lengths(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] b);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_IN_LENGTH;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= REG_OUT_LENGTH;
    cfg_data  <= b;
    @(posedge clk);
    cfg_we  <= 1'b0;
    in_len  = a;
    out_len = b;
    cfg_cnt++;
  endtask

  initial begin : stimulus
    int               rand_cnt;
    int               lines;
    int               kind;
    int               len;
    int               na;
    logic [LEN_W-1:0] a;
    logic [LEN_W-1:0] b;
    rand_cnt = 0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // no line start after reset gives an overlong line at lengths of one, then two one-sample lines
    queue_beat(32'h7FFF_FFFF, 1'b0);
    queue_beat(32'h8000_0000, 1'b0);
    queue_beat(32'hFFFF_FFFF, 1'b1);
    queue_beat(32'h0000_0000, 1'b1);

    // compression: all-negative groups give zero, then a positive line
    set_lengths(13'd5, 13'd2);
    queue_beat(32'(-5 * 65536), 1'b1);
    queue_beat(32'(-3 * 65536), 1'b0);
    queue_beat(32'hFFFF_FFFF, 1'b0);
    queue_beat(32'h8000_0000, 1'b0);
    queue_beat(32'(-2 * 65536), 1'b0);
    queue_beat(32'h0001_8000, 1'b1);
    queue_beat(32'h7FFF_FFFF, 1'b0);
    queue_beat(32'h0000_0001, 1'b0);

    // expansion past the run cap, then the rest of the line
    set_lengths(13'd1, 13'd70);
    queue_beat(32'h1234_5678, 1'b1);
    queue_beat(32'hEDCB_A987, 1'b0);

    // zero in_length expands with capped runs; zero out_length drops all
    set_lengths(13'd0, 13'd5);
    queue_beat(32'hA5A5_5A5A, 1'b1);
    set_lengths(13'd3, 13'd0);
    queue_beat(32'h5A5A_A5A5, 1'b1);
    queue_beat(32'h0000_1000, 1'b0);

    // lengths above the maximum clamp to a copy
    set_lengths(13'h1FFF, 13'h1FFF);
    queue_beat(32'h8000_0001, 1'b1);
    queue_beat(32'h7FFF_FFFE, 1'b0);

    // a whole expanded line plus one sample past its end
    set_lengths(13'd3, 13'd8);
    queue_beat(32'h0003_0000, 1'b1);
    queue_beat(32'h0002_0000, 1'b0);
    queue_beat(32'h0001_0000, 1'b0);
    queue_beat(32'hFFFF_0000, 1'b0);

    // output held off while the input keeps offering beats
    set_lengths(13'd4, 13'd4);
    for (int i = 0; i < 40; i++) queue_beat(pick_sample(), (i % 4) == 0);
    rand_cnt += 40;
    @(negedge clk);
    long_hold_req = 1'b1;

    while (rand_cnt < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          a = 13'($urandom_range(1, 8));
          b = 13'(a + $urandom_range(1, 16));
        end
        4, 5, 6: begin
          b = 13'($urandom_range(1, 8));
          a = 13'(b + $urandom_range(1, 16));
        end
        7: begin
          a = 13'($urandom_range(1, 16));
          b = a;
        end
        8: begin
          a = pick_extreme_len();
          b = pick_extreme_len();
        end
        default: begin
          a = 13'($urandom_range(1, 3));
          b = 13'($urandom_range(100, 300));
        end
      endcase
      set_lengths(a, b);
      if (rand_cnt >= RANDOM_ITEMS - 50) begin
        quiet    = 1'b1;
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      na = clamp_len(a);
      lines = $urandom_range(1, 4);
      for (int ln = 0; ln < lines; ln++) begin
        kind = $urandom_range(0, 9);
        len = (na == 0) ? $urandom_range(1, 4) : ((na > 24) ? 24 : na);
        if (kind == 8) len = $urandom_range(1, len + 3);
        for (int i = 0; i < len; i++) begin
          if (kind == 9)
            queue_beat(pick_sample(), $urandom_range(0, 3) == 0);
          else
            queue_beat(pick_sample(), i == 0);
        end
        rand_cnt += len;
      end
    end

    settle();
    $display("%0d samples accepted over %0d length settings, %0d result beats checked",
             acc_cnt, cfg_cnt, res_cnt);
    $display("copy, replicate and max-hold modes, capped runs, zero and clamped lengths, %0d-cycle stall",
             LONG_HOLD);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
